>>> rtl/mstb_pkg.sv
`default_nettype none

package mstb_pkg;

    localparam int DEF_NUM_DELAY_TIMERS = 8;
    localparam int DEF_NUM_LOOP_TIMERS  = 8;
    localparam int DEF_COUNT_BITS       = 16;

    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 16;
    localparam int MASK_W  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_ARM_DELAY  = 3'd1,
        FUNC_ARM_LOOP   = 3'd2,
        FUNC_POLL_DELAY = 3'd3,
        FUNC_POLL_LOOP  = 3'd4
    } func_t;

endpackage

`default_nettype wire

>>> rtl/mstb_req_if.sv
`default_nettype none

interface mstb_req_if import mstb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] timer_index;
    logic [VALUE_W-1:0] load_value;
    logic               clear_flag;

    modport source (
        output valid,
        output func,
        output timer_index,
        output load_value,
        output clear_flag,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  timer_index,
        input  load_value,
        input  clear_flag,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/mstb_rsp_if.sv
`default_nettype none

interface mstb_rsp_if import mstb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               fired;
    logic [VALUE_W-1:0] count_now;
    logic [MASK_W-1:0]  delay_fired_mask;
    logic [MASK_W-1:0]  loop_fired_mask;

    modport source (
        output valid,
        output fired,
        output count_now,
        output delay_fired_mask,
        output loop_fired_mask,
        input  ready
    );

    modport sink (
        input  valid,
        input  fired,
        input  count_now,
        input  delay_fired_mask,
        input  loop_fired_mask,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/multi_software_timer_bank.sv
// Timer bank: one-shot delay timers and auto-reload loop timers with sticky
// fired flags.
// req channel (valid/ready): one request per operation: tick, arm delay,
// arm loop, poll delay, poll loop, with timer index, load value, clear flag.
// rsp channel (valid/ready): exactly one response per request, in order,
// carrying the polled flag and count plus both fired masks after the request.
// Path: an accepted request is held in the input register, then loads the
// result register, which shows rsp.valid from then on; the timer state is
// updated at the same edge that loads the result register.
// Throughput: one request per cycle while rsp is not held off, set by the single
// pass of decrement/compare logic from the input register to the state registers.
// Stall: while rsp is held off, the result register keeps its response and
// the input register can still take one more request; req.ready then drops.
// Reset (rst_n low, asynchronous): all counts, periods and flags clear, both
// pipeline registers empty.
`default_nettype none

module multi_software_timer_bank import mstb_pkg::*; #(
    parameter int NUM_DELAY_TIMERS = DEF_NUM_DELAY_TIMERS,
    parameter int NUM_LOOP_TIMERS  = DEF_NUM_LOOP_TIMERS,
    parameter int COUNT_BITS       = DEF_COUNT_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mstb_req_if.sink    req,
    mstb_rsp_if.source  rsp
);

    logic                  s1_valid_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [COUNT_BITS-1:0] value_reg;
    logic                  clear_reg;

    logic [COUNT_BITS-1:0] delay_cnt_reg  [NUM_DELAY_TIMERS];
    logic [COUNT_BITS-1:0] delay_cnt_next [NUM_DELAY_TIMERS];
    logic [COUNT_BITS-1:0] loop_cnt_reg   [NUM_LOOP_TIMERS];
    logic [COUNT_BITS-1:0] loop_cnt_next  [NUM_LOOP_TIMERS];
    logic [COUNT_BITS-1:0] loop_per_reg   [NUM_LOOP_TIMERS];
    logic [COUNT_BITS-1:0] loop_per_next  [NUM_LOOP_TIMERS];
    logic [NUM_DELAY_TIMERS-1:0] delay_flag_reg;
    logic [NUM_DELAY_TIMERS-1:0] delay_flag_next;
    logic [NUM_LOOP_TIMERS-1:0]  loop_flag_reg;
    logic [NUM_LOOP_TIMERS-1:0]  loop_flag_next;

    logic                  out_valid_reg;
    logic                  out_fired_reg;
    logic                  out_fired_next;
    logic [VALUE_W-1:0]    out_count_reg;
    logic [VALUE_W-1:0]    out_count_next;
    logic [MASK_W-1:0]     out_dmask_reg;
    logic [MASK_W-1:0]     out_lmask_reg;

    logic advance;
    logic fire;
    logic req_accept;

    logic op_tick;
    logic op_arm_delay;
    logic op_arm_loop;
    logic op_poll_delay;
    logic op_poll_loop;

    logic [COUNT_BITS-1:0] delay_dec [NUM_DELAY_TIMERS];
    logic [COUNT_BITS-1:0] loop_dec  [NUM_LOOP_TIMERS];
    logic [COUNT_BITS-1:0] sel_count;
    logic                  sel_fired;

    assign advance    = !out_valid_reg || rsp.ready;
    assign fire       = s1_valid_reg && advance;
    assign req.ready  = !s1_valid_reg || advance;
    assign req_accept = req.valid && req.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            func_reg  <= req.func;
            index_reg <= req.timer_index;
            value_reg <= COUNT_BITS'(req.load_value);
            clear_reg <= req.clear_flag;
        end
    end

    always_comb
    begin
        op_tick       = 1'b0;
        op_arm_delay  = 1'b0;
        op_arm_loop   = 1'b0;
        op_poll_delay = 1'b0;
        op_poll_loop  = 1'b0;
        case (func_t'(func_reg))
            FUNC_TICK:       op_tick       = 1'b1;
            FUNC_ARM_DELAY:  op_arm_delay  = 1'b1;
            FUNC_ARM_LOOP:   op_arm_loop   = 1'b1;
            FUNC_POLL_DELAY: op_poll_delay = 1'b1;
            FUNC_POLL_LOOP:  op_poll_loop  = 1'b1;
            default:         ;
        endcase
    end

    // delay timers: stick at zero, flag set on every tick there
    always_comb
    begin
        for (int i = 0; i < NUM_DELAY_TIMERS; i++)
        begin
            delay_dec[i] = (delay_cnt_reg[i] != '0) ? delay_cnt_reg[i] - COUNT_BITS'(1)
                                                    : delay_cnt_reg[i];
            delay_cnt_next[i]  = delay_cnt_reg[i];
            delay_flag_next[i] = delay_flag_reg[i];
            if (op_tick)
            begin
                delay_cnt_next[i] = delay_dec[i];
                if (delay_dec[i] == '0)
                begin
                    delay_flag_next[i] = 1'b1;
                end
            end
            else if (index_reg == INDEX_W'(i))
            begin
                if (op_arm_delay)
                begin
                    delay_cnt_next[i]  = value_reg;
                    delay_flag_next[i] = 1'b0;
                end
                else if (op_poll_delay && clear_reg)
                begin
                    delay_flag_next[i] = 1'b0;
                end
            end
        end
    end

    // loop timers: reload period on reaching zero
    always_comb
    begin
        for (int i = 0; i < NUM_LOOP_TIMERS; i++)
        begin
            loop_dec[i] = (loop_cnt_reg[i] != '0) ? loop_cnt_reg[i] - COUNT_BITS'(1)
                                                  : loop_cnt_reg[i];
            loop_cnt_next[i]  = loop_cnt_reg[i];
            loop_per_next[i]  = loop_per_reg[i];
            loop_flag_next[i] = loop_flag_reg[i];
            if (op_tick)
            begin
                if (loop_dec[i] == '0)
                begin
                    loop_flag_next[i] = 1'b1;
                    loop_cnt_next[i]  = loop_per_reg[i];
                end
                else
                begin
                    loop_cnt_next[i] = loop_dec[i];
                end
            end
            else if (index_reg == INDEX_W'(i))
            begin
                if (op_arm_loop)
                begin
                    loop_cnt_next[i]  = value_reg;
                    loop_per_next[i]  = value_reg;
                    loop_flag_next[i] = 1'b0;
                end
                else if (op_poll_loop && clear_reg)
                begin
                    loop_flag_next[i] = 1'b0;
                end
            end
        end
    end

    // poll readout, zero when index is out of range or not a poll
    always_comb
    begin
        sel_count = '0;
        sel_fired = 1'b0;
        for (int i = 0; i < NUM_DELAY_TIMERS; i++)
        begin
            if (op_poll_delay && index_reg == INDEX_W'(i))
            begin
                sel_count = delay_cnt_reg[i];
                sel_fired = delay_flag_reg[i];
            end
        end
        for (int i = 0; i < NUM_LOOP_TIMERS; i++)
        begin
            if (op_poll_loop && index_reg == INDEX_W'(i))
            begin
                sel_count = loop_cnt_reg[i];
                sel_fired = loop_flag_reg[i];
            end
        end
        out_fired_next = sel_fired;
        out_count_next = VALUE_W'(sel_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DELAY_TIMERS; i++)
            begin
                delay_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_LOOP_TIMERS; i++)
            begin
                loop_cnt_reg[i] <= '0;
                loop_per_reg[i] <= '0;
            end
            delay_flag_reg <= '0;
            loop_flag_reg  <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_DELAY_TIMERS; i++)
            begin
                delay_cnt_reg[i] <= delay_cnt_next[i];
            end
            for (int i = 0; i < NUM_LOOP_TIMERS; i++)
            begin
                loop_cnt_reg[i] <= loop_cnt_next[i];
                loop_per_reg[i] <= loop_per_next[i];
            end
            delay_flag_reg <= delay_flag_next;
            loop_flag_reg  <= loop_flag_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_fired_reg <= out_fired_next;
            out_count_reg <= out_count_next;
            out_dmask_reg <= MASK_W'(delay_flag_next);
            out_lmask_reg <= MASK_W'(loop_flag_next);
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.fired            = out_fired_reg;
    assign rsp.count_now        = out_count_reg;
    assign rsp.delay_fired_mask = out_dmask_reg;
    assign rsp.loop_fired_mask  = out_lmask_reg;

endmodule

`default_nettype wire

>>> rtl/mstb_checker.sv
`default_nettype none

module mstb_checker import mstb_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               rsp_fired,
    input wire logic [VALUE_W-1:0] rsp_count_now,
    input wire logic [MASK_W-1:0]  rsp_delay_fired_mask,
    input wire logic [MASK_W-1:0]  rsp_loop_fired_mask
);

    // a response held off keeps its valid
    ap_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // a response held off keeps its payload
    ap_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_fired) && $stable(rsp_count_now)
            && $stable(rsp_delay_fired_mask) && $stable(rsp_loop_fired_mask))
        else $error("response payload changed while stalled");

    // an accepted request passes the input register and reaches the output when not blocked
    ap_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
        else $error("request did not produce a response in time");

    // a response only appears from an earlier request
    ap_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without request");

endmodule

bind multi_software_timer_bank mstb_checker u_mstb_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_fired            (rsp.fired),
    .rsp_count_now        (rsp.count_now),
    .rsp_delay_fired_mask (rsp.delay_fired_mask),
    .rsp_loop_fired_mask  (rsp.loop_fired_mask)
);

`default_nettype wire

>>> tb/multi_software_timer_bank_tb.sv
`timescale 1ns / 1ps

class timer_bank_scoreboard;

    typedef struct {
        logic                        fired;
        logic [mstb_pkg::VALUE_W-1:0] count_now;
        logic [mstb_pkg::MASK_W-1:0]  delay_mask;
        logic [mstb_pkg::MASK_W-1:0]  loop_mask;
    } timer_status_t;

    localparam int CNT_W   = mstb_pkg::DEF_COUNT_BITS;
    localparam int N_DELAY = mstb_pkg::DEF_NUM_DELAY_TIMERS;
    localparam int N_LOOP  = mstb_pkg::DEF_NUM_LOOP_TIMERS;

    logic [CNT_W-1:0]            delay_cnt[N_DELAY];
    logic [CNT_W-1:0]            loop_cnt[N_LOOP];
    logic [CNT_W-1:0]            loop_period[N_LOOP];
    logic [mstb_pkg::MASK_W-1:0] delay_flags;
    logic [mstb_pkg::MASK_W-1:0] loop_flags;
    timer_status_t               expected_status[$];
    int                          mismatches;

    function new();
        for (int i = 0; i < N_DELAY; i++)
        begin
            delay_cnt[i] = '0;
        end
        for (int i = 0; i < N_LOOP; i++)
        begin
            loop_cnt[i]    = '0;
            loop_period[i] = '0;
        end
        delay_flags = '0;
        loop_flags  = '0;
        mismatches  = 0;
    endfunction

    function void advance_tick();
        for (int i = 0; i < N_DELAY; i++)
        begin
            if (delay_cnt[i] != '0)
                delay_cnt[i] = delay_cnt[i] - 1'b1;
            if (delay_cnt[i] == '0)
                delay_flags[i] = 1'b1;
        end
        for (int i = 0; i < N_LOOP; i++)
        begin
            if (loop_cnt[i] != '0)
                loop_cnt[i] = loop_cnt[i] - 1'b1;
            if (loop_cnt[i] == '0)
            begin
                loop_flags[i] = 1'b1;
                loop_cnt[i]   = loop_period[i];
            end
        end
    endfunction

    function void note_request(logic [mstb_pkg::FUNC_W-1:0] f,
                               logic [mstb_pkg::INDEX_W-1:0] idx,
                               logic [mstb_pkg::VALUE_W-1:0] val, logic clr);
        timer_status_t st;
        logic          dok;
        logic          lok;
        st.fired     = 1'b0;
        st.count_now = '0;
        dok = idx < N_DELAY;
        lok = idx < N_LOOP;
        case (f)
            mstb_pkg::FUNC_TICK:
                advance_tick();
            mstb_pkg::FUNC_ARM_DELAY:
                if (dok)
                begin
                    delay_cnt[idx]   = CNT_W'(val);
                    delay_flags[idx] = 1'b0;
                end
            mstb_pkg::FUNC_ARM_LOOP:
                if (lok)
                begin
                    loop_period[idx] = CNT_W'(val);
                    loop_cnt[idx]    = CNT_W'(val);
                    loop_flags[idx]  = 1'b0;
                end
            mstb_pkg::FUNC_POLL_DELAY:
                if (dok)
                begin
                    st.fired     = delay_flags[idx];
                    st.count_now = mstb_pkg::VALUE_W'(delay_cnt[idx]);
                    if (clr)
                        delay_flags[idx] = 1'b0;
                end
            mstb_pkg::FUNC_POLL_LOOP:
                if (lok)
                begin
                    st.fired     = loop_flags[idx];
                    st.count_now = mstb_pkg::VALUE_W'(loop_cnt[idx]);
                    if (clr)
                        loop_flags[idx] = 1'b0;
                end
            default:
                ;
        endcase
        st.delay_mask = delay_flags;
        st.loop_mask  = loop_flags;
        expected_status.push_back(st);
    endfunction

    task report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task check_response(logic fired, logic [mstb_pkg::VALUE_W-1:0] count_now,
                        logic [mstb_pkg::MASK_W-1:0] delay_mask,
                        logic [mstb_pkg::MASK_W-1:0] loop_mask);
        timer_status_t st;
        if (expected_status.size() == 0)
        begin
            report_mismatch("unrequested response", count_now, 0);
        end
        else
        begin
            st = expected_status.pop_front();
            if (fired !== st.fired)
                report_mismatch("fired", fired, st.fired);
            if (count_now !== st.count_now)
                report_mismatch("count_now", count_now, st.count_now);
            if (delay_mask !== st.delay_mask)
                report_mismatch("delay_fired_mask", delay_mask, st.delay_mask);
            if (loop_mask !== st.loop_mask)
                report_mismatch("loop_fired_mask", loop_mask, st.loop_mask);
        end
    endtask

    function int pending_count();
        return expected_status.size();
    endfunction

endclass

module multi_software_timer_bank_tb;

    import mstb_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int IDLE_LIMIT      = 2000;

    logic clk;
    logic rst_n;
    int   burst_left;

    mstb_req_if req();
    mstb_rsp_if rsp();

    timer_bank_scoreboard tracker = new();

    multi_software_timer_bank uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic clr);
        int gap;
        req.valid       <= 1'b1;
        req.func        <= f;
        req.timer_index <= idx;
        req.load_value  <= val;
        req.clear_flag  <= clr;
        do
            @(posedge clk);
        while (!req.ready);
        tracker.note_request(f, idx, val, clr);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // mostly small counts so timers actually expire between polls
    task automatic send_random_request(output bit effective);
        int unsigned        pick;
        int unsigned        vsel;
        logic [FUNC_W-1:0]  f;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        logic               clr;
        pick = $urandom_range(0, 99);
        vsel = $urandom_range(0, 9);
        idx  = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(8, 15))
                                           : INDEX_W'($urandom_range(0, 7));
        if (vsel < 7)
            val = VALUE_W'($urandom_range(0, 12));
        else if (vsel < 9)
            val = VALUE_W'($urandom_range(0, 300));
        else
            val = VALUE_W'($urandom);
        clr = 1'($urandom);
        if (pick < 40)
            f = FUNC_TICK;
        else if (pick < 55)
            f = FUNC_ARM_DELAY;
        else if (pick < 65)
            f = FUNC_ARM_LOOP;
        else if (pick < 80)
            f = FUNC_POLL_DELAY;
        else if (pick < 96)
            f = FUNC_POLL_LOOP;
        else
            f = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        effective = (f == FUNC_TICK)
                 || ((f == FUNC_ARM_DELAY || f == FUNC_POLL_DELAY) && idx < DEF_NUM_DELAY_TIMERS)
                 || ((f == FUNC_ARM_LOOP || f == FUNC_POLL_LOOP) && idx < DEF_NUM_LOOP_TIMERS);
        send_request(f, idx, val, clr);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            tracker.check_response(rsp.fired, rsp.count_now,
                                   rsp.delay_fired_mask, rsp.loop_fired_mask);
    end

    // response side: ready stretches, random stalls, two long hold-offs
    initial
    begin : sink_pattern
        int cyc;
        cyc = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if ((cyc >= 250 && cyc < 330) || (cyc >= 1100 && cyc < 1160))
                rsp.ready <= 1'b0;
            else if ((cyc / 128) % 3 == 0)
                rsp.ready <= 1'b1;
            else if ((cyc / 128) % 3 == 1)
                rsp.ready <= ($urandom_range(0, 3) != 0);
            else
                rsp.ready <= ((cyc % 5) != 2) && ($urandom_range(0, 5) != 0);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("multi_software_timer_bank test failed");
        $finish;
    end

    initial
    begin : stimulus
        int effective_sent;
        bit effective;
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.func        <= FUNC_TICK;
        req.timer_index <= '0;
        req.load_value  <= '0;
        req.clear_flag  <= 1'b0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, then a tick on all-zero counters fires everything
        send_request(FUNC_POLL_DELAY, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_TICK, 4'd0, 16'hFFFF, 1'b1);
        send_request(FUNC_POLL_LOOP, 4'd7, 16'h0000, 1'b1);
        send_request(FUNC_ARM_DELAY, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_ARM_DELAY, 4'd7, 16'hFFFF, 1'b1);
        send_request(FUNC_ARM_LOOP, 4'd3, 16'h0000, 1'b0);
        send_request(FUNC_ARM_LOOP, 4'd7, 16'hFFFF, 1'b0);
        // index beyond the bank
        send_request(FUNC_ARM_DELAY, 4'd8, 16'h0005, 1'b1);
        send_request(FUNC_ARM_LOOP, 4'd15, 16'hAAAA, 1'b0);
        for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
            send_request(FUNC_W'(f), 4'd2, 16'h5555, 1'b1);
        send_request(FUNC_ARM_DELAY, 4'd1, 16'h0002, 1'b0);
        send_request(FUNC_TICK, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_TICK, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_POLL_DELAY, 4'd1, 16'h0000, 1'b0);
        send_request(FUNC_POLL_DELAY, 4'd1, 16'h0000, 1'b1);
        send_request(FUNC_POLL_DELAY, 4'd1, 16'h0000, 1'b0);
        send_request(FUNC_ARM_LOOP, 4'd2, 16'h0001, 1'b1);
        send_request(FUNC_TICK, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_POLL_LOOP, 4'd2, 16'h0000, 1'b1);
        send_request(FUNC_TICK, 4'd0, 16'h0000, 1'b0);
        send_request(FUNC_POLL_LOOP, 4'd3, 16'h0000, 1'b0);
        send_request(FUNC_POLL_DELAY, 4'd15, 16'hFFFF, 1'b1);
        send_request(FUNC_POLL_LOOP, 4'd8, 16'hFFFF, 1'b1);

        effective_sent = 0;
        while (effective_sent < RANDOM_REQUESTS)
        begin
            send_random_request(effective);
            if (effective)
                effective_sent++;
        end
        req.valid <= 1'b0;

        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
            $display("multi_software_timer_bank test passed");
        else
            $display("multi_software_timer_bank test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mstb_pkg.sv
rtl/mstb_req_if.sv
rtl/mstb_rsp_if.sv
rtl/multi_software_timer_bank.sv
rtl/mstb_checker.sv
tb/multi_software_timer_bank_tb.sv
